### src/pid_voltage_regulator_defines.svh
// Assertion macros for the PID voltage regulator.
// Included by the top level; depends on nothing else.
`ifndef PID_VOLTAGE_REGULATOR_DEFINES_SVH
`define PID_VOLTAGE_REGULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDVR_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pid_voltage_regulator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDVR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pid_voltage_regulator: next-cycle check failed");

`endif

### src/pidvr_pkg.sv
// Package for the PID voltage regulator: field widths, register indexes,
// reset values and default parameters. Depends on nothing.
package pidvr_pkg;

  // Field widths of the transaction payloads and registers.
  localparam int IN_W   = 13;
  localparam int ERR_W  = 14;
  localparam int OUT_W  = 14;
  localparam int COEF_W = 16;
  localparam int OFFS_W = 13;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Default parameter values.
  localparam int DEF_SCALE_DIVISOR = 1000;
  localparam int DEF_DRIVE_MAX     = 5000;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [2:0]               reg_idx_t;

  // Register indexes (byte address divided by four).
  localparam reg_idx_t REG_COEF_ERR_NOW      = 3'd0;
  localparam reg_idx_t REG_COEF_ERR_PREV     = 3'd1;
  localparam reg_idx_t REG_COEF_ERR_OLDER    = 3'd2;
  localparam reg_idx_t REG_COEF_DRIVE_PREV   = 3'd3;
  localparam reg_idx_t REG_COEF_DRIVE_OLDER  = 3'd4;
  localparam reg_idx_t REG_DISTURBANCE_OFFS  = 3'd5;

  // Register reset values.
  localparam coef_t RST_COEF_ERR_NOW     = 16'sd1189;
  localparam coef_t RST_COEF_ERR_PREV    = -16'sd2132;
  localparam coef_t RST_COEF_ERR_OLDER   = 16'sd954;
  localparam coef_t RST_COEF_DRIVE_PREV  = 16'sd1749;
  localparam coef_t RST_COEF_DRIVE_OLDER = -16'sd749;

endpackage

### src/pid_voltage_regulator.sv
// Top level of the PID voltage regulator: input register, difference-equation
// datapath, history registers, result register and APB-style register port.
// Depends on pidvr_pkg and pid_voltage_regulator_defines.svh.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------------
//   in      | sink      | in_valid / in_stall    | in_reference_mv, in_measured_mv
//   out     | source    | out_valid / out_stall  | out_drive_mv
//   cfg     | sink      | psel/penable/pready    | paddr, pwdata, pwrite, prdata
//
// One transaction is accepted per cycle unless in_stall is high; its result
// goes from the input register to the result register. The cycle time is
// set by the drive feedback loop: five coefficient products, their sum, a
// reciprocal multiply for the constant divide and the clamp, all between the
// input register and the history and result registers.
// Reset clears the histories and both valid flags and loads default weights.
// A stall on the result side holds the result and fills the input register.

`include "pid_voltage_regulator_defines.svh"

module pid_voltage_regulator #(
  parameter int SCALE_DIVISOR = pidvr_pkg::DEF_SCALE_DIVISOR,
  parameter int DRIVE_MAX     = pidvr_pkg::DEF_DRIVE_MAX
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pidvr_pkg::IN_W-1:0]   in_reference_mv,
  input  logic [pidvr_pkg::IN_W-1:0]   in_measured_mv,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pidvr_pkg::OUT_W-1:0]  out_drive_mv,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidvr_pkg::ADDR_W-1:0] paddr,
  input  logic [pidvr_pkg::DATA_W-1:0] pwdata,
  output logic [pidvr_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  // Derived widths and constants.
  localparam int COEF_W = pidvr_pkg::COEF_W;
  localparam int ERR_W  = pidvr_pkg::ERR_W;
  localparam int OFFS_W = pidvr_pkg::OFFS_W;
  localparam int OUT_W  = pidvr_pkg::OUT_W;
  localparam int DRV_W  = $clog2(DRIVE_MAX + 1);
  localparam int PROD_W = (COEF_W + ERR_W > COEF_W + DRV_W + 1) ?
                          (COEF_W + ERR_W) : (COEF_W + DRV_W + 1);
  localparam int ACC_W  = PROD_W + 3;
  localparam int SUM_W  = 17;

  localparam logic [63:0] LIM   = 64'(SCALE_DIVISOR) * 64'(DRIVE_MAX);
  localparam int          QN_W  = (LIM > 64'd1) ? $clog2(LIM) : 1;
  localparam int          DIV_L = $clog2(SCALE_DIVISOR);
  localparam int          K     = QN_W + DIV_L;
  localparam int          M_W   = QN_W + 2;
  localparam int          QP_W  = K + DRV_W;
  localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(SCALE_DIVISOR) - 64'd1) /
                                  64'(SCALE_DIVISOR);

  localparam logic [M_W-1:0]   RECIP_M = RECIP[M_W-1:0];
  localparam logic [ACC_W-1:0] LIM_A   = LIM[ACC_W-1:0];
  localparam logic [31:0]      DMAX32  = 32'(DRIVE_MAX);
  localparam logic [DRV_W-1:0] DMAX_D  = DMAX32[DRV_W-1:0];

  // Configuration registers.
  pidvr_pkg::coef_t    c_err_now_r, c_err_prev_r, c_err_older_r;
  pidvr_pkg::coef_t    c_drv_prev_r, c_drv_older_r;
  logic [OFFS_W-1:0]   offs_r;

  // Input register stage.
  logic                    s1_v_r, s1_v_nxt;
  logic signed [ERR_W-1:0] s1_err_r;

  // Histories.
  logic signed [ERR_W-1:0] err_prev_r, err_older_r;
  logic [DRV_W-1:0]        drv_prev_r, drv_older_r;

  // Result register.
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_drive_r, out_drive_nxt;

  // Handshake and datapath signals.
  logic                    in_acc, adv, cfg_wr;
  pidvr_pkg::reg_idx_t     cfg_idx;
  logic [OFFS_W-1:0]       offs_in, offs_sat;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]  acc;
  logic [QN_W-1:0]          dvd;
  logic [QP_W-1:0]          qprod;
  logic [DRV_W-1:0]         drv_q;

  // Pipeline control: the input register moves on whenever the result
  // register is empty or being emptied in this cycle.
  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Coefficient products for the current and past errors and drives.
  assign p0 = PROD_W'(c_err_now_r)   * PROD_W'(s1_err_r);
  assign p1 = PROD_W'(c_err_prev_r)  * PROD_W'(err_prev_r);
  assign p2 = PROD_W'(c_err_older_r) * PROD_W'(err_older_r);
  assign p3 = PROD_W'(c_drv_prev_r)  * PROD_W'($signed({1'b0, drv_prev_r}));
  assign p4 = PROD_W'(c_drv_older_r) * PROD_W'($signed({1'b0, drv_older_r}));

  assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(p3) + ACC_W'(p4);

  // Divide by the scale through a reciprocal multiply. It is exact for every
  // dividend below the clamp limit, which is the only range where it is used.
  assign dvd   = acc[QN_W-1:0];
  assign qprod = QP_W'(dvd) * QP_W'(RECIP_M);

  // Clamp: a sum at or below zero gives zero, one at or above the limit gives
  // the full-scale drive.
  always_comb begin
    priority if (acc[ACC_W-1] || (acc == '0)) begin
      drv_q = '0;
    end else if ($unsigned(acc) >= LIM_A) begin
      drv_q = DMAX_D;
    end else begin
      drv_q = qprod[K +: DRV_W];
    end
  end

  assign out_drive_nxt = OUT_W'(SUM_W'(drv_q) + SUM_W'(offs_r));

  // Datapath and history registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      err_prev_r  <= '0;
      err_older_r <= '0;
      drv_prev_r  <= '0;
      drv_older_r <= '0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        err_prev_r  <= s1_err_r;
        err_older_r <= err_prev_r;
        drv_prev_r  <= drv_q;
        drv_older_r <= drv_prev_r;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r <= $signed({1'b0, in_reference_mv}) - $signed({1'b0, in_measured_mv});
    end
    if (adv) begin
      out_drive_r <= out_drive_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_drive_mv = out_drive_r;

  // Register port: the offset saturates at the full-scale drive on write.
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[4:2];
  assign offs_in  = pwdata[OFFS_W-1:0];
  assign offs_sat = (32'(offs_in) > DMAX32) ? DMAX32[OFFS_W-1:0] : offs_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_err_now_r   <= pidvr_pkg::RST_COEF_ERR_NOW;
      c_err_prev_r  <= pidvr_pkg::RST_COEF_ERR_PREV;
      c_err_older_r <= pidvr_pkg::RST_COEF_ERR_OLDER;
      c_drv_prev_r  <= pidvr_pkg::RST_COEF_DRIVE_PREV;
      c_drv_older_r <= pidvr_pkg::RST_COEF_DRIVE_OLDER;
      offs_r        <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pidvr_pkg::REG_COEF_ERR_NOW:     c_err_now_r   <= pwdata[COEF_W-1:0];
        pidvr_pkg::REG_COEF_ERR_PREV:    c_err_prev_r  <= pwdata[COEF_W-1:0];
        pidvr_pkg::REG_COEF_ERR_OLDER:   c_err_older_r <= pwdata[COEF_W-1:0];
        pidvr_pkg::REG_COEF_DRIVE_PREV:  c_drv_prev_r  <= pwdata[COEF_W-1:0];
        pidvr_pkg::REG_COEF_DRIVE_OLDER: c_drv_older_r <= pwdata[COEF_W-1:0];
        pidvr_pkg::REG_DISTURBANCE_OFFS: offs_r        <= offs_sat;
        default: ;
      endcase
    end
  end

  // Read-back; weights are sign-extended to the bus width.
  always_comb begin
    unique case (cfg_idx)
      pidvr_pkg::REG_COEF_ERR_NOW:     prdata = 32'(c_err_now_r);
      pidvr_pkg::REG_COEF_ERR_PREV:    prdata = 32'(c_err_prev_r);
      pidvr_pkg::REG_COEF_ERR_OLDER:   prdata = 32'(c_err_older_r);
      pidvr_pkg::REG_COEF_DRIVE_PREV:  prdata = 32'(c_drv_prev_r);
      pidvr_pkg::REG_COEF_DRIVE_OLDER: prdata = 32'(c_drv_older_r);
      pidvr_pkg::REG_DISTURBANCE_OFFS: prdata = 32'(offs_r);
      default:                         prdata = '0;
    endcase
  end

  // Assertions.
  // The input side stalls only when both stages are full and the result is held.
  `PIDVR_ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, (s1_v_r && out_valid_r && out_stall))
  // The stored drive never exceeds full scale.
  `PIDVR_ASSERT_IMPL(a_drive_in_range, clk, rst_n, 1'b1, (drv_prev_r <= DMAX_D))
  // Each transaction that leaves the input register shifts the drive history.
  `PIDVR_ASSERT_NEXT(a_history_shift, clk, rst_n, adv, (drv_older_r == $past(drv_prev_r)))

endmodule

### sim/tb_top.sv
// Self-checking testbench for pid_voltage_regulator: random and directed voltage
// samples, register writes and read-back, with a scoreboard predicting each drive.
// Depends on pidvr_pkg and the regulator RTL only.
`timescale 1ns / 1ps

module tb_top;

  // Widths and types taken from the package.
  localparam int IN_W   = pidvr_pkg::IN_W;
  localparam int ERR_W  = pidvr_pkg::ERR_W;
  localparam int OUT_W  = pidvr_pkg::OUT_W;
  localparam int COEF_W = pidvr_pkg::COEF_W;
  localparam int OFFS_W = pidvr_pkg::OFFS_W;
  localparam int ADDR_W = pidvr_pkg::ADDR_W;
  localparam int DATA_W = pidvr_pkg::DATA_W;
  typedef pidvr_pkg::coef_t coef_t;

  localparam int CLK_PERIOD    = 20;
  localparam int LONG_HOLD     = 80;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_DIRECTED  = 16;
  localparam int TIMEOUT_NS    = 4_000_000;
  // Addresses past the last register; writes there must change nothing.
  localparam int UNUSED_IDX_A  = 6;
  localparam int UNUSED_IDX_B  = 7;
  localparam logic [DATA_W-1:0] COEF_MASK = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] OFFS_MASK = 32'h0000_1FFF;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_EVERY_THIRD, STALL_HEAVY} stall_style_t;

  // Predicts the drive of every accepted sample and checks results in order.
  class drive_scoreboard_t;
    coef_t                   w_err_now, w_err_prev, w_err_older, w_drv_prev, w_drv_older;
    logic [OFFS_W-1:0]       offset_mv;
    logic signed [ERR_W-1:0] err_last, err_older;
    logic [IN_W-1:0]         drv_last, drv_older;
    logic [OUT_W-1:0]        expected_drive_q[$];
    int                      checked_count;
    int                      fail_count;

    function new();
      w_err_now     = pidvr_pkg::RST_COEF_ERR_NOW;
      w_err_prev    = pidvr_pkg::RST_COEF_ERR_PREV;
      w_err_older   = pidvr_pkg::RST_COEF_ERR_OLDER;
      w_drv_prev    = pidvr_pkg::RST_COEF_DRIVE_PREV;
      w_drv_older   = pidvr_pkg::RST_COEF_DRIVE_OLDER;
      offset_mv     = '0;
      err_last      = '0;
      err_older     = '0;
      drv_last      = '0;
      drv_older     = '0;
      checked_count = 0;
      fail_count    = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    function int pending();
      return expected_drive_q.size();
    endfunction

    // Mirror of a register write; the offset saturates at the drive ceiling.
    function void write_register(int idx, logic [DATA_W-1:0] value);
      case (idx)
        pidvr_pkg::REG_COEF_ERR_NOW:     w_err_now   = coef_t'(value[COEF_W-1:0]);
        pidvr_pkg::REG_COEF_ERR_PREV:    w_err_prev  = coef_t'(value[COEF_W-1:0]);
        pidvr_pkg::REG_COEF_ERR_OLDER:   w_err_older = coef_t'(value[COEF_W-1:0]);
        pidvr_pkg::REG_COEF_DRIVE_PREV:  w_drv_prev  = coef_t'(value[COEF_W-1:0]);
        pidvr_pkg::REG_COEF_DRIVE_OLDER: w_drv_older = coef_t'(value[COEF_W-1:0]);
        pidvr_pkg::REG_DISTURBANCE_OFFS: begin
          if (value[OFFS_W-1:0] > pidvr_pkg::DEF_DRIVE_MAX)
            offset_mv = OFFS_W'(pidvr_pkg::DEF_DRIVE_MAX);
          else offset_mv = value[OFFS_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(int idx);
      case (idx)
        pidvr_pkg::REG_COEF_ERR_NOW:     return DATA_W'(w_err_now);
        pidvr_pkg::REG_COEF_ERR_PREV:    return DATA_W'(w_err_prev);
        pidvr_pkg::REG_COEF_ERR_OLDER:   return DATA_W'(w_err_older);
        pidvr_pkg::REG_COEF_DRIVE_PREV:  return DATA_W'(w_drv_prev);
        pidvr_pkg::REG_COEF_DRIVE_OLDER: return DATA_W'(w_drv_older);
        pidvr_pkg::REG_DISTURBANCE_OFFS: return DATA_W'(offset_mv);
        default:                         return '0;
      endcase
    endfunction

    // Difference equation: weighted errors and drives, divide, clamp, shift histories.
    function void note_sample(logic [IN_W-1:0] ref_mv, logic [IN_W-1:0] meas_mv);
      longint err_now, acc, quo;
      err_now = longint'(ref_mv) - longint'(meas_mv);
      acc = longint'(w_err_now) * err_now
          + longint'(w_err_prev) * longint'(err_last)
          + longint'(w_err_older) * longint'(err_older)
          + longint'(w_drv_prev) * longint'(drv_last)
          + longint'(w_drv_older) * longint'(drv_older);
      quo = acc / longint'(pidvr_pkg::DEF_SCALE_DIVISOR);
      if (quo < 0) quo = 0;
      if (quo > pidvr_pkg::DEF_DRIVE_MAX) quo = pidvr_pkg::DEF_DRIVE_MAX;
      err_older = err_last;
      err_last  = err_now[ERR_W-1:0];
      drv_older = drv_last;
      drv_last  = quo[IN_W-1:0];
      expected_drive_q.push_back(OUT_W'(quo + longint'(offset_mv)));
    endfunction

    task check_drive(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_drive_q.size() == 0) begin
        report($sformatf("drive_mv %0d arrived with no sample outstanding", got));
      end else begin
        want = expected_drive_q.pop_front();
        checked_count++;
        if (got !== want) report($sformatf("drive_mv got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [IN_W-1:0]   in_reference_mv;
  logic [IN_W-1:0]   in_measured_mv;
  logic              out_valid;
  logic              out_stall;
  logic [OUT_W-1:0]  out_drive_mv;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  drive_scoreboard_t sb;
  int                hold_asks;
  int                setpoint_mv;
  int                samples_sent;
  int                settings_used;
  coef_t             weights [5];

  // Directed samples: field extremes, negative and saturating quotients, bit patterns.
  logic [IN_W-1:0] dir_ref_mv [NUM_DIRECTED] = '{
    13'd0, 13'd5000, 13'd0, 13'd8191, 13'd0, 13'd8191, 13'd5000, 13'd2500,
    13'd2500, 13'd2600, 13'd2400, 13'h1555, 13'h0AAA, 13'd8191, 13'd0, 13'd3300};
  logic [IN_W-1:0] dir_meas_mv [NUM_DIRECTED] = '{
    13'd0, 13'd0, 13'd5000, 13'd0, 13'd8191, 13'd8191, 13'd5000, 13'd2500,
    13'd2600, 13'd2400, 13'd2500, 13'h0AAA, 13'h1555, 13'd1, 13'd8190, 13'd3300};

  pid_voltage_regulator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_reference_mv (in_reference_mv),
    .in_measured_mv  (in_measured_mv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_mv    (out_drive_mv),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offers one sample and waits until the transaction is accepted; valid stays high.
  task automatic send_sample(input logic [IN_W-1:0] ref_mv, input logic [IN_W-1:0] meas_mv);
    in_valid        <= 1'b1;
    in_reference_mv <= ref_mv;
    in_measured_mv  <= meas_mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(ref_mv, meas_mv);
    samples_sent++;
  endtask

  // Mostly a regulated loop near a setpoint, otherwise the full 13-bit range.
  task automatic pick_sample(output logic [IN_W-1:0] ref_mv, output logic [IN_W-1:0] meas_mv);
    int sel, meas;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      if ($urandom_range(0, 15) == 0) setpoint_mv = $urandom_range(0, 5000);
      meas = setpoint_mv + int'($urandom_range(0, 600)) - 300;
      if (meas < 0) meas = 0;
      ref_mv  = IN_W'(setpoint_mv);
      meas_mv = IN_W'(meas);
    end else if (sel < 90) begin
      ref_mv  = IN_W'($urandom_range(0, 8191));
      meas_mv = IN_W'($urandom_range(0, 8191));
    end else begin
      ref_mv  = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'd8191;
      meas_mv = ($urandom_range(0, 2) == 0) ? 13'd5000 : IN_W'($urandom_range(0, 8191));
    end
  endtask

  // Sends samples in bursts of random length with random gaps between them.
  task automatic run_items(input int count, input int max_gap);
    int done_items, burst, gap;
    logic [IN_W-1:0] ref_mv, meas_mv;
    done_items = 0;
    while (done_items < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && done_items < count) begin
        pick_sample(ref_mv, meas_mv);
        send_sample(ref_mv, meas_mv);
        burst--;
        done_items++;
      end
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering samples until every predicted drive has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reads every register back and compares the bits that the field defines.
  task automatic read_all_regs();
    int idx;
    logic [DATA_W-1:0] got, mask;
    for (idx = int'(pidvr_pkg::REG_COEF_ERR_NOW);
         idx <= int'(pidvr_pkg::REG_DISTURBANCE_OFFS); idx++) begin
      mask = (idx == int'(pidvr_pkg::REG_DISTURBANCE_OFFS)) ? OFFS_MASK : COEF_MASK;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(idx * 4);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      if ((got & mask) !== (sb.reg_value(idx) & mask))
        sb.report($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, got & mask,
                            sb.reg_value(idx) & mask));
    end
  endtask

  // Writes all weights and the offset, with junk in the unused upper data bits.
  task automatic apply_setting(input coef_t coefs [5], input int offset_val);
    int k;
    for (k = 0; k < 5; k++)
      write_reg(int'(pidvr_pkg::REG_COEF_ERR_NOW) + k, {16'($urandom()), coefs[k]});
    write_reg(int'(pidvr_pkg::REG_DISTURBANCE_OFFS), {19'($urandom()), 13'(offset_val)});
    read_all_regs();
    settings_used++;
  endtask

  function automatic coef_t random_coef();
    if ($urandom_range(0, 3) == 0) return coef_t'($urandom_range(0, 65535));
    return coef_t'($urandom_range(0, 6000) - 3000);
  endfunction

  // Result side: checks each accepted transaction and stalls on its own pattern.
  initial begin : result_side
    int           hold_left, hold_seen, style_left, cyc;
    stall_style_t style;
    hold_left  = 0;
    hold_seen  = 0;
    style_left = 0;
    cyc        = 0;
    style      = STALL_NONE;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) sb.check_drive(out_drive_mv);
      cyc++;
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          STALL_NONE:        out_stall <= 1'b0;
          STALL_LIGHT:       out_stall <= ($urandom_range(0, 99) < 30);
          STALL_EVERY_THIRD: out_stall <= (cyc % 3 == 0);
          default:           out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  // Main sequence: reset, then one phase per coefficient setting.
  initial begin : stimulus
    int k, p, offset_val;
    sb              = new();
    hold_asks       = 0;
    setpoint_mv     = 2500;
    samples_sent    = 0;
    settings_used   = 1;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_reference_mv = '0;
    in_measured_mv  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset weights: check the register defaults, then the directed samples.
    read_all_regs();
    for (k = 0; k < NUM_DIRECTED; k++) send_sample(dir_ref_mv[k], dir_meas_mv[k]);
    run_items(PHASE_ITEMS - NUM_DIRECTED, 6);
    drain_results();

    // Largest positive weights and the highest legal offset.
    for (k = 0; k < 5; k++) weights[k] = 16'sh7FFF;
    apply_setting(weights, pidvr_pkg::DEF_DRIVE_MAX);
    run_items(PHASE_ITEMS, 4);
    drain_results();

    // Most negative weights, an offset above range, and a long result-side hold
    // while samples keep coming so that the input side backs up.
    for (k = 0; k < 5; k++) weights[k] = -16'sh8000;
    apply_setting(weights, 8191);
    run_items(30, 4);
    hold_asks++;
    run_items(40, 0);
    run_items(30, 4);
    drain_results();

    // Proportional term only; writes to unmapped addresses must be ignored.
    weights = '{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    apply_setting(weights, 1);
    write_reg(UNUSED_IDX_A, $urandom());
    write_reg(UNUSED_IDX_B, $urandom());
    read_all_regs();
    run_items(PHASE_ITEMS, 6);
    drain_results();

    // Random weights and offsets; the first one pauses mid-phase for a full drain.
    for (p = 0; p < 4; p++) begin
      for (k = 0; k < 5; k++) weights[k] = random_coef();
      offset_val = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 5000)
                                                : $urandom_range(0, 8191);
      apply_setting(weights, offset_val);
      run_items(PHASE_ITEMS / 2, 8);
      if (p == 0) drain_results();
      run_items(PHASE_ITEMS / 2, 8);
      drain_results();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d voltage samples across %0d weight and offset settings.",
             samples_sent, settings_used);
    $display("%0d drive results compared, %0d mismatches, %0d still outstanding.",
             sb.checked_count, sb.fail_count, sb.pending());
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
